// ===== hdl/lwas_pkg.sv =====
// ----------------------------------------------------------------------------
// lwas_pkg
// shared types and constants of the link watchdog alarm supervisor
// ----------------------------------------------------------------------------
package lwas_pkg;

    localparam int MS_PER_SECOND = 1000;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int AGE_W         = 32;
    localparam int CNT_W         = 32;
    localparam int DELAY_W       = 16;
    localparam int THR_W         = 26;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_DELAY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DETECT_EN    = 2'd2;

    localparam logic [15:0] TIMEOUT_RST     = 16'd10;
    localparam logic [15:0] ALARM_DELAY_RST = 16'd0;
    localparam logic        DETECT_EN_RST   = 1'b1;

    typedef struct packed {
        logic [15:0] timeout_seconds;
        logic [15:0] alarm_delay_seconds;
        logic        detect_enable;
    } cfg_t;

    typedef struct packed {
        logic             subscription_valid;
        logic [AGE_W-1:0] update_age_ms;
        logic             blocked;
        logic             alarm_rearm;
    } item_t;

    typedef struct packed {
        logic             link_is_up;
        logic             went_down;
        logic             went_up;
        logic [CNT_W-1:0] up_transitions;
        logic             action_active;
        logic             alarm_raised;
        logic             return_raised;
        logic             delay_running;
    } result_t;

endpackage

// ===== hdl/lwas_cfg.sv =====
// ----------------------------------------------------------------------------
// lwas_cfg
// configuration registers, written through a plain write port
// ----------------------------------------------------------------------------
module lwas_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lwas_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lwas_pkg::CFG_DATA_W-1:0]     cfg_data,
    output lwas_pkg::cfg_t                      cfg
);

    lwas_pkg::cfg_t cfg_reg;
    lwas_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                lwas_pkg::REG_TIMEOUT:     cfg_next.timeout_seconds     = cfg_data;
                lwas_pkg::REG_ALARM_DELAY: cfg_next.alarm_delay_seconds = cfg_data;
                lwas_pkg::REG_DETECT_EN:   cfg_next.detect_enable       = cfg_data[0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_seconds     <= lwas_pkg::TIMEOUT_RST;
            cfg_reg.alarm_delay_seconds <= lwas_pkg::ALARM_DELAY_RST;
            cfg_reg.detect_enable       <= lwas_pkg::DETECT_EN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/lwas_core.sv =====
// ----------------------------------------------------------------------------
// lwas_core
// link state, delay timer and alarm detection with the result register
// ----------------------------------------------------------------------------
module lwas_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  lwas_pkg::cfg_t      cfg,
    input  logic                item_valid,
    input  lwas_pkg::item_t     item,
    output logic                item_take,
    output logic                out_valid,
    input  logic                out_stall,
    output lwas_pkg::result_t   result
);

    logic                           link_state_reg,   link_state_next;
    logic [lwas_pkg::CNT_W-1:0]     up_counter_reg,   up_counter_next;
    logic                           action_flag_reg,  action_flag_next;
    logic                           return_armed_reg, return_armed_next;
    logic                           alarm_armed_reg,  alarm_armed_next;
    logic                           detect_armed_reg, detect_armed_next;
    logic                           delay_flag_reg,   delay_flag_next;
    logic [lwas_pkg::DELAY_W-1:0]   delay_count_reg,  delay_count_next;
    logic                           delay_listed_reg, delay_listed_next;
    logic                           out_valid_reg,    out_valid_next;
    lwas_pkg::result_t              result_reg,       result_next;

    logic [lwas_pkg::THR_W-1:0]     thr_ms;
    logic                           now_up;
    logic                           alarm_pulse;
    logic                           return_pulse;

    // result register free or being emptied this cycle
    assign item_take = item_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        link_state_next   = link_state_reg;
        up_counter_next   = up_counter_reg;
        action_flag_next  = action_flag_reg;
        return_armed_next = return_armed_reg;
        alarm_armed_next  = alarm_armed_reg;
        detect_armed_next = detect_armed_reg;
        delay_flag_next   = delay_flag_reg;
        delay_count_next  = delay_count_reg;
        delay_listed_next = delay_listed_reg;
        alarm_pulse       = 1'b0;
        return_pulse      = 1'b0;
        result_next       = result_reg;

        // delay timer step
        if (delay_listed_reg)
        begin
            if ((delay_count_reg <= lwas_pkg::DELAY_W'(1)) || !delay_flag_reg)
            begin
                delay_count_next  = '0;
                delay_flag_next   = 1'b0;
                delay_listed_next = 1'b0;
            end
            else
            begin
                delay_count_next = delay_count_reg - lwas_pkg::DELAY_W'(1);
            end
        end

        thr_ms = lwas_pkg::THR_W'(cfg.timeout_seconds)
               * lwas_pkg::THR_W'(lwas_pkg::MS_PER_SECOND);
        now_up = item.subscription_valid
              && (item.update_age_ms < lwas_pkg::AGE_W'(thr_ms));

        result_next.went_down = link_state_reg && !now_up;
        result_next.went_up   = !link_state_reg && now_up;
        link_state_next       = now_up;
        if (!link_state_reg && now_up)
        begin
            up_counter_next = up_counter_reg + lwas_pkg::CNT_W'(1);
        end

        if (item.alarm_rearm)
        begin
            alarm_armed_next = 1'b1;
        end

        if (now_up)
        begin
            action_flag_next = 1'b0;
            if (return_armed_reg)
            begin
                return_armed_next = 1'b0;
                return_pulse      = 1'b1;
            end
            if (alarm_armed_next && !detect_armed_reg)
            begin
                delay_flag_next   = 1'b0;
                detect_armed_next = 1'b1;
            end
        end
        else
        begin
            action_flag_next = 1'b1;
            if (alarm_armed_next && cfg.detect_enable && !item.blocked)
            begin
                if (detect_armed_reg)
                begin
                    delay_count_next = cfg.alarm_delay_seconds;
                    if (!delay_flag_next && (cfg.alarm_delay_seconds != '0))
                    begin
                        delay_listed_next = 1'b1;
                        delay_flag_next   = 1'b1;
                    end
                    detect_armed_next = 1'b0;
                end
                if (!delay_flag_next)
                begin
                    alarm_pulse       = 1'b1;
                    return_armed_next = 1'b1;
                    alarm_armed_next  = 1'b0;
                end
            end
        end

        result_next.link_is_up     = now_up;
        result_next.up_transitions = up_counter_next;
        result_next.action_active  = action_flag_next;
        result_next.alarm_raised   = alarm_pulse;
        result_next.return_raised  = return_pulse;
        result_next.delay_running  = delay_flag_next;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (item_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_state_reg   <= 1'b0;
            up_counter_reg   <= '0;
            action_flag_reg  <= 1'b0;
            return_armed_reg <= 1'b0;
            alarm_armed_reg  <= 1'b1;
            detect_armed_reg <= 1'b1;
            delay_flag_reg   <= 1'b0;
            delay_count_reg  <= '0;
            delay_listed_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (item_take)
            begin
                link_state_reg   <= link_state_next;
                up_counter_reg   <= up_counter_next;
                action_flag_reg  <= action_flag_next;
                return_armed_reg <= return_armed_next;
                alarm_armed_reg  <= alarm_armed_next;
                detect_armed_reg <= detect_armed_next;
                delay_flag_reg   <= delay_flag_next;
                delay_count_reg  <= delay_count_next;
                delay_listed_reg <= delay_listed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// ===== hdl/link_watchdog_alarm_supervisor_unit.sv =====
// ----------------------------------------------------------------------------
// link_watchdog_alarm_supervisor_unit
// single-link watchdog with delayed link-lost alarm, one scan tick per item
// ----------------------------------------------------------------------------
// One item is one scan tick of the supervised link. Items pass an input
// register and then one stage of flag and timer logic into the result
// register, so the block takes one item every cycle while out_stall is low;
// a result is offered by the result register once its item has passed the
// input register and that stage. The timeout compare (timeout times one
// thousand against the age) sets the depth of that stage. Configuration is
// taken at any time but must only be changed while no item is in flight.
// Reset values: timeout 10 s, alarm delay 0 s, detection enabled.
module link_watchdog_alarm_supervisor_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lwas_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lwas_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                subscription_valid,
    input  logic [lwas_pkg::AGE_W-1:0]          update_age_ms,
    input  logic                                blocked,
    input  logic                                alarm_rearm,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                link_is_up,
    output logic                                went_down,
    output logic                                went_up,
    output logic [lwas_pkg::CNT_W-1:0]          up_transitions,
    output logic                                action_active,
    output logic                                alarm_raised,
    output logic                                return_raised,
    output logic                                delay_running
);

    lwas_pkg::cfg_t     cfg;
    lwas_pkg::item_t    item_reg;
    logic               in_vld_reg, in_vld_next;
    logic               item_take;
    logic               in_take;
    lwas_pkg::result_t  result;

    lwas_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register
    assign in_stall = in_vld_reg && !item_take;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_take)
        begin
            in_vld_next = 1'b1;
        end
        else if (item_take)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.subscription_valid <= subscription_valid;
            item_reg.update_age_ms      <= update_age_ms;
            item_reg.blocked            <= blocked;
            item_reg.alarm_rearm        <= alarm_rearm;
        end
    end

    lwas_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (in_vld_reg),
        .item       (item_reg),
        .item_take  (item_take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result     (result)
    );

    assign link_is_up     = result.link_is_up;
    assign went_down      = result.went_down;
    assign went_up        = result.went_up;
    assign up_transitions = result.up_transitions;
    assign action_active  = result.action_active;
    assign alarm_raised   = result.alarm_raised;
    assign return_raised  = result.return_raised;
    assign delay_running  = result.delay_running;

endmodule
